/* hw/rtl/pva_pkg.sv */
package pva_pkg;

  // Number of voices held in the cell chain (2 to 16).
  localparam int unsigned NumVoices = 4;
  localparam int unsigned CntW      = $clog2(NumVoices);
  localparam int unsigned NoteW     = 7;
  localparam int unsigned IndexW    = 4;

  typedef struct packed {
    logic [NoteW-1:0] pitch;
    logic [NoteW-1:0] vel;
  } voice_t;

  typedef struct packed {
    logic             note_on;
    logic [NoteW-1:0] note_number;
    logic [NoteW-1:0] velocity;
  } pva_in_t;

  typedef struct packed {
    logic [IndexW-1:0] voice_index;
    logic [NoteW-1:0]  voice_note;
    logic [NoteW-1:0]  voice_level;
    logic              last_voice;
  } pva_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } pva_state_e;

endpackage

/* hw/rtl/pva_cell.sv */
module pva_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  pva_pkg::voice_t voice_i,
  output pva_pkg::voice_t voice_o
);
  import pva_pkg::*;

  voice_t voice_q;

  // Advance one place along the ring when enabled, hold otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else if (shift_i) begin
      voice_q <= voice_i;
    end
  end

  assign voice_o = voice_q;

endmodule

/* hw/rtl/pva_ctrl.sv */
module pva_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pva_pkg::pva_in_t  event_i,
  input  pva_pkg::voice_t   head_i,
  output pva_pkg::voice_t   feed_o,
  output logic             shift_o,
  output pva_pkg::pva_out_t result_o,
  output logic             result_valid_o
);
  import pva_pkg::*;

  localparam logic [CntW-1:0] LastIdx = CntW'(NumVoices - 1);

  pva_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  pva_in_t          event_q;
  logic             free_found_q, free_found_d;
  logic [CntW-1:0]  free_idx_q, free_idx_d;
  logic [CntW-1:0]  best_idx_q, best_idx_d;
  logic [NoteW-1:0] best_pitch_q, best_pitch_d;
  pva_out_t         result_q, result_d;
  logic             result_valid_q, result_valid_d;

  logic             accept;
  logic             alloc;
  logic [CntW-1:0]  slot;
  voice_t           upd;

  assign accept = start && (state_q == ST_IDLE);
  assign alloc  = event_q.note_on && (event_q.velocity != '0);
  assign slot   = free_found_q ? free_idx_q : best_idx_q;

  // Apply the event to the voice at the head of the ring.
  always_comb begin
    upd = head_i;
    if (alloc) begin
      if (cnt_q == slot) begin
        upd.pitch = event_q.note_number;
        upd.vel   = event_q.velocity;
      end
    end else if (head_i.pitch == event_q.note_number) begin
      upd.vel = '0;
    end
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    free_found_d   = free_found_q;
    free_idx_d     = free_idx_q;
    best_idx_d     = best_idx_q;
    best_pitch_d   = best_pitch_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    shift_o        = 1'b0;
    feed_o         = head_i;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d        = '0;
        free_found_d = 1'b0;
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift_o = 1'b1;
        if (!free_found_q && (head_i.vel == '0)) begin
          free_found_d = 1'b1;
          free_idx_d   = cnt_q;
        end
        if ((cnt_q == '0) || (head_i.pitch > best_pitch_q)) begin
          best_idx_d   = cnt_q;
          best_pitch_d = head_i.pitch;
        end
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = ST_REPORT;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_REPORT: begin
        shift_o                = 1'b1;
        feed_o                 = upd;
        result_valid_d         = 1'b1;
        result_d.voice_index   = IndexW'(cnt_q);
        result_d.voice_note    = upd.pitch;
        result_d.voice_level   = upd.vel;
        result_d.last_voice    = (cnt_q == LastIdx);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      free_found_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      free_found_q   <= free_found_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_i;
    end
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_pitch_q <= best_pitch_d;
    result_q     <= result_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  a_word_from_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(state_q == ST_REPORT))
    else $error("result word without a report cycle");

  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && result_q.last_voice) |-> (state_q == ST_IDLE))
    else $error("last voice reported but run not finished");

  a_scan_to_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == LastIdx) |=> (state_q == ST_REPORT && cnt_q == '0))
    else $error("scan did not hand over to report at voice zero");

  a_accept_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN && cnt_q == '0 && !free_found_q))
    else $error("accepted event did not start a fresh scan");

endmodule

/* hw/rtl/poly_voice_allocator.sv */
// Polyphonic voice allocator. Raise start with a note event on event_i; the
// event is taken at a clock edge where start is high and busy is low. The
// voices sit in a ring of NumVoices cells that rotates one place per cycle
// while busy: a first lap scans the voices in index order for the lowest free
// voice and the highest held pitch, a second lap applies the event at the
// head of the ring and emits one report word per voice, voice 0 first, with
// last_voice set on the final one. Each word is on result_o for exactly one
// cycle, flagged by result_valid_o, and cannot be held off, so the receiver
// must take it then. One event occupies the block for two laps of the ring
// after acceptance, and busy stays high meanwhile, so a new event is taken
// only once the last is through. A note-on with nonzero velocity takes the
// lowest-indexed free voice or, if none is free, steals the highest pitch
// (lowest index on a tie). A note-off, or a note-on with zero velocity,
// zeroes the velocity of every voice holding that pitch.
module poly_voice_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pva_pkg::pva_in_t  event_i,
  output pva_pkg::pva_out_t result_o,
  output logic              result_valid_o
);
  import pva_pkg::*;

  // Cell NumVoices-1 is the head of the ring; cell 0 takes the write-back.
  voice_t ring   [NumVoices];
  voice_t feed;
  logic   shift;

  for (genvar k = 0; k < NumVoices; k++) begin : g_cell
    voice_t cell_in;
    if (k == 0) begin : g_first
      assign cell_in = feed;
    end else begin : g_next
      assign cell_in = ring[k-1];
    end
    pva_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .voice_i (cell_in),
      .voice_o (ring[k])
    );
  end

  // Sequence the two laps, track the steal candidate and drive the words.
  pva_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .event_i        (event_i),
    .head_i         (ring[NumVoices-1]),
    .feed_o         (feed),
    .shift_o        (shift),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

/* tb/sv/poly_voice_allocator_tb.sv */
module poly_voice_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pva_pkg::*;

  // Two laps of the voice ring per event, plus slack for the final report word.
  localparam int unsigned EventCycles = 2 * NumVoices + 2;
  // Roughly 410 events in all; the limit allows many times the cycles they take.
  localparam int unsigned CycleLimit  = 200000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  pva_in_t  event_i;
  pva_out_t result_o;
  logic     result_valid_o;

  // Shadow copy of the voice bank, updated as each event word is taken.
  logic [NoteW-1:0] held_pitch [NumVoices];
  logic [NoteW-1:0] held_level [NumVoices];

  // Report words still owed by the block, oldest first.
  pva_out_t pending_reports [$];

  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;
  bit          sender_idles = 1'b1;

  poly_voice_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .event_i        (event_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  always #5ns clk_i = ~clk_i;

  // Apply one accepted event to the shadow bank and queue the full report run
  // that must follow it. A note-on with nonzero velocity takes the first free
  // voice, or steals the highest pitch (lowest index on a tie); anything else
  // is a release that clears the level of every voice holding the pitch and
  // leaves all pitches alone.
  function automatic void allocate_voice(input pva_in_t ev);
    int       slot;
    pva_out_t word;
    slot = -1;
    if (ev.note_on && ev.velocity != '0) begin
      for (int v = 0; v < NumVoices; v++) begin
        if (slot < 0 && held_level[v] == '0) slot = v;
      end
      if (slot < 0) begin
        slot = 0;
        for (int v = 1; v < NumVoices; v++) begin
          if (held_pitch[v] > held_pitch[slot]) slot = v;
        end
      end
      held_pitch[slot] = ev.note_number;
      held_level[slot] = ev.velocity;
    end else begin
      for (int v = 0; v < NumVoices; v++) begin
        if (held_pitch[v] == ev.note_number) held_level[v] = '0;
      end
    end
    for (int v = 0; v < NumVoices; v++) begin
      word.voice_index = IndexW'(v);
      word.voice_note  = held_pitch[v];
      word.voice_level = held_level[v];
      word.last_voice  = (v == NumVoices - 1);
      pending_reports.push_back(word);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // Take every report word at the edge that ends its cycle; the block cannot
  // be held off, so there is nothing to drive on this side.
  always @(posedge clk_i) begin : check_reports
    pva_out_t want;
    if (rst_ni === 1'b1 && result_valid_o !== 1'b0) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report word expected none actual %p", $time, result_o);
        fault_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("voice_index", 16'(want.voice_index), 16'(result_o.voice_index));
        check_field("voice_note",  16'(want.voice_note),  16'(result_o.voice_note));
        check_field("voice_level", 16'(want.voice_level), 16'(result_o.voice_level));
        check_field("last_voice",  16'(want.last_voice),  16'(result_o.last_voice));
      end
    end
  end

  // Guard against a hung handshake or a report run that never finishes.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("poly_voice_allocator: mismatch");
      $finish;
    end
  end

  // Offer one event word and hold it until the block takes it. When idling, start
  // drops at random on any cycle, busy or not, so the gaps land on every phase of
  // the two laps. Start is left as it is on the accepting edge: the next call or
  // the drain decides its next value, so it is never driven twice in a step.
  task automatic send_note(input bit on, input int note, input int vel);
    pva_in_t ev;
    ev.note_on     = on;
    ev.note_number = NoteW'(note);
    ev.velocity    = NoteW'(vel);
    event_i <= ev;
    start   <= !sender_idles || $urandom_range(99) >= 25;
    forever begin
      @(posedge clk_i);
      if (start && !busy) break;
      start <= !sender_idles || $urandom_range(99) >= 25;
    end
    allocate_voice(ev);
  endtask

  // Drop start, let every owed report word arrive, then give the block time
  // to settle back to idle.
  task automatic drain_reports();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (EventCycles) @(posedge clk_i);
  endtask

  // Straight out of reset every voice is free with pitch zero: a release of
  // note zero matches them all and must leave them at zero.
  task automatic test_reset_release();
    send_note(1'b0, 0, 127);
    drain_reports();
  endtask

  // Fill the bank, with one pitch held twice, then steal. The first steal hits
  // the tie on pitch 127 and must take the lower voice.
  task automatic test_fill_and_steal();
    send_note(1'b1, 0, 127);
    send_note(1'b1, 127, 1);
    send_note(1'b1, 64, 100);
    for (int v = 3; v < NumVoices; v++) send_note(1'b1, 127, 64);
    send_note(1'b1, 10, 5);
    send_note(1'b1, 127, 127);
    drain_reports();
  endtask

  // Releases of every flavour: note-off carrying a velocity, a pitch nobody
  // holds, note-on at zero velocity, a free voice still tagged with the pitch,
  // and a release of a pitch that was overwritten. Then free the whole bank,
  // refill it at one pitch and steal across a full tie.
  task automatic test_release_cases();
    send_note(1'b0, 127, 127);
    send_note(1'b0, 99, 0);
    send_note(1'b1, 0, 0);
    send_note(1'b0, 127, 55);
    send_note(1'b1, 50, 20);
    send_note(1'b0, 0, 0);
    send_note(1'b0, 50, 1);
    send_note(1'b0, 10, 0);
    send_note(1'b0, 64, 0);
    for (int v = 0; v < NumVoices; v++) send_note(1'b1, 0, v + 1);
    send_note(1'b1, 1, 127);
    send_note(1'b1, 1, 3);
    drain_reports();
  endtask

  // Pitches mostly cluster in a narrow band or sit at the extremes, so collisions,
  // ties and full banks are frequent.
  function automatic int pick_pitch();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return $urandom_range(67, 60);
    if (roll < 65) return $urandom_range(1) ? 127 : 0;
    return $urandom_range(127);
  endfunction

  // Mostly musical traffic: note-ons, and releases aimed at a pitch some voice
  // holds. The rest is arbitrary words, zero-velocity note-ons included.
  task automatic test_random_traffic(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        send_note(1'b1, pick_pitch(), $urandom_range(127, 1));
      end else if (roll < 70) begin
        send_note(1'b0, int'(held_pitch[$urandom_range(NumVoices - 1)]),
                  $urandom_range(127));
      end else if (roll < 80) begin
        send_note(1'b1, int'(held_pitch[$urandom_range(NumVoices - 1)]), 0);
      end else begin
        send_note(1'($urandom_range(1)), $urandom_range(127), $urandom_range(127));
      end
    end
  endtask

  initial begin
    for (int v = 0; v < NumVoices; v++) begin
      held_pitch[v] = '0;
      held_level[v] = '0;
    end
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    event_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_release();
    test_fill_and_steal();
    test_release_cases();

    // Idle at random, then a long run with start held up, then idle again.
    test_random_traffic(150);
    drain_reports();
    sender_idles = 1'b0;
    test_random_traffic(120);
    sender_idles = 1'b1;
    test_random_traffic(120);
    drain_reports();

    if (fault_count == 0) begin
      $display("poly_voice_allocator: match");
    end else begin
      $display("poly_voice_allocator: mismatch");
    end
    $finish;
  end

endmodule
